// File: rtl/dcb_pkg.sv
// shared types and constants for the display capture blend core
`default_nettype none

package dcb_pkg;

    localparam int LINE_W   = 8;
    localparam int PIX_W    = 8;
    localparam int APIX_W   = 32;
    localparam int BPIX_W   = 16;
    localparam int BANK_W   = 2;
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 16;
    localparam int DIRTY_W  = 9;
    localparam int CHAN_W   = 5;
    localparam int WEIGHT_W = 5;
    localparam int MODE_W   = 2;
    localparam int SIZE_W   = 2;
    localparam int BLOCK_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    localparam int BLOCK_SHIFT = 14;
    localparam int BASE_W      = BLOCK_W + BLOCK_SHIFT + 1;
    localparam int PROD_W      = CHAN_W + WEIGHT_W;
    localparam int SUM_W       = PROD_W;
    localparam int ROUND_SHIFT = 4;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = WEIGHT_W'(16);
    localparam logic [CHAN_W-1:0]   CHAN_MAX   = {CHAN_W{1'b1}};
    localparam logic [SUM_W-1:0]    ROUND_ADD  = SUM_W'(8);

    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK     = 3'd5;

    localparam logic [MODE_W-1:0] MODE_SRC_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SRC_B = 2'd1;

    localparam logic [SIZE_W-1:0] SIZE_128X128 = 2'd0;

    typedef struct packed {
        logic [LINE_W-1:0] line_number;
        logic [PIX_W-1:0]  pixel_index;
        logic [APIX_W-1:0] a_pixel;
        logic [BPIX_W-1:0] b_pixel;
        logic              b_present;
        logic              bank_mapped;
    } pixel_t;

    typedef struct packed {
        logic               write_enable;
        logic [BANK_W-1:0]  write_bank;
        logic [ADDR_W-1:0]  write_address;
        logic [DATA_W-1:0]  write_data;
        logic [DIRTY_W-1:0] dirty_block;
    } result_t;

    typedef logic [CHAN_W-1:0] chan3_t [3];
    typedef logic [PROD_W-1:0] prod3_t [3];

endpackage

`default_nettype wire

// File: rtl/display_capture_blend_core.sv
// top level of the display capture blend core, a three stage pixel pipeline
//
// usage: one capture pixel beat enters on pixel when start is high; busy is
// always low, so a beat may be offered in every clock cycle. each beat gives
// exactly one result beat on result, marked by done for one cycle, after
// the stage 1, stage 2 and output registers. throughput is one beat per
// cycle; the beat passes the three register stages (geometry and channel
// decode, channel by weight multiply, rounded sum and saturation).
// configuration: cfg_write with cfg_index and cfg_data writes one register
// at the edge; registers must be written only while no beat is in flight,
// which the block does not enforce. outside the capture area or with an
// unmapped bank the result carries a cleared write; a pixel past the line
// width still reports the dirty block. reset clears all configuration
// registers and the stage valid bits; no result is produced until a beat
// is accepted. the receiver cannot stall, so the pipeline never holds.
`default_nettype none

module display_capture_blend_core
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire dcb_pkg::pixel_t                   pixel,
    input  wire logic                              cfg_write,
    input  wire logic [dcb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dcb_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                   done,
    output dcb_pkg::result_t                       result
);
    import dcb_pkg::*;

    // configuration registers
    logic [MODE_W-1:0]   mode_reg;
    logic [WEIGHT_W-1:0] weight_a_reg;
    logic [WEIGHT_W-1:0] weight_b_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [BLOCK_W-1:0]  block_reg;
    logic [BANK_W-1:0]   bank_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= '0;
            weight_a_reg <= '0;
            weight_b_reg <= '0;
            size_reg     <= '0;
            block_reg    <= '0;
            bank_reg     <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MODE:     mode_reg     <= cfg_data[MODE_W-1:0];
                CFG_WEIGHT_A: weight_a_reg <= cfg_data[WEIGHT_W-1:0];
                CFG_WEIGHT_B: weight_b_reg <= cfg_data[WEIGHT_W-1:0];
                CFG_SIZE:     size_reg     <= cfg_data[SIZE_W-1:0];
                CFG_BLOCK:    block_reg    <= cfg_data[BLOCK_W-1:0];
                CFG_BANK:     bank_reg     <= cfg_data[BANK_W-1:0];
                default:      ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // stage 1: geometry, channel decode, effective weights
    logic [LINE_W-1:0]   height;
    logic                wide;
    logic                line_ok;
    logic                pix_ok;
    logic [ADDR_W-1:0]   line_off;
    logic [BASE_W-1:0]   base;
    chan3_t              chan_a;
    chan3_t              chan_b;
    logic                alpha_a;
    logic                alpha_b;
    logic [WEIGHT_W-1:0] eva;
    logic [WEIGHT_W-1:0] evb;
    logic [WEIGHT_W-1:0] wa_eff;
    logic [WEIGHT_W-1:0] wb_eff;
    logic [DATA_W-1:0]   a15;
    logic [DATA_W-1:0]   direct_data;

    always_comb
    begin
        wide    = (size_reg != SIZE_128X128);
        height  = wide ? {size_reg, 6'b0} : 8'd128;
        line_ok = (pixel.line_number < height) && pixel.bank_mapped;
        pix_ok  = wide || !pixel.pixel_index[PIX_W-1];
        line_off = wide ? {pixel.line_number, 8'b0}
                        : {1'b0, pixel.line_number, 7'b0};
        base = {1'b0, block_reg, {BLOCK_SHIFT{1'b0}}} + {1'b0, line_off};

        for (int i = 0; i < 3; i++)
        begin
            chan_a[i] = pixel.a_pixel[8*i+1 +: CHAN_W];
            chan_b[i] = pixel.b_pixel[CHAN_W*i +: CHAN_W];
        end
        alpha_a = (pixel.a_pixel[31:24] != 8'd0);
        alpha_b = pixel.b_pixel[15] && pixel.b_present;

        eva    = (weight_a_reg > WEIGHT_MAX) ? WEIGHT_MAX : weight_a_reg;
        evb    = (weight_b_reg > WEIGHT_MAX) ? WEIGHT_MAX : weight_b_reg;
        wa_eff = alpha_a ? eva : '0;
        wb_eff = alpha_b ? evb : '0;

        a15 = {alpha_a, chan_a[2], chan_a[1], chan_a[0]};
        if (mode_reg == MODE_SRC_A)
            direct_data = a15;
        else
            direct_data = pixel.b_present ? pixel.b_pixel : '0;
    end

    logic                s1_valid_reg;
    logic                s1_line_ok_reg;
    logic                s1_pix_ok_reg;
    logic                s1_blend_reg;
    logic [BASE_W-1:0]   s1_base_reg;
    logic [PIX_W-1:0]    s1_pix_reg;
    chan3_t              s1_chan_a_reg;
    chan3_t              s1_chan_b_reg;
    logic [WEIGHT_W-1:0] s1_wa_reg;
    logic [WEIGHT_W-1:0] s1_wb_reg;
    logic [DATA_W-1:0]   s1_direct_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        s1_line_ok_reg <= line_ok;
        s1_pix_ok_reg  <= pix_ok;
        s1_blend_reg   <= (mode_reg != MODE_SRC_A) && (mode_reg != MODE_SRC_B);
        s1_base_reg    <= base;
        s1_pix_reg     <= pixel.pixel_index;
        s1_chan_a_reg  <= chan_a;
        s1_chan_b_reg  <= chan_b;
        s1_wa_reg      <= wa_eff;
        s1_wb_reg      <= wb_eff;
        s1_direct_reg  <= direct_data;
    end

    // stage 2: channel by weight products, address
    prod3_t             prod_a;
    prod3_t             prod_b;
    logic [ADDR_W-1:0]  address;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_a[i] = PROD_W'(s1_chan_a_reg[i]) * PROD_W'(s1_wa_reg);
            prod_b[i] = PROD_W'(s1_chan_b_reg[i]) * PROD_W'(s1_wb_reg);
        end
        address = s1_base_reg[ADDR_W-1:0] + {{(ADDR_W-PIX_W){1'b0}}, s1_pix_reg};
    end

    logic               s2_valid_reg;
    logic               s2_line_ok_reg;
    logic               s2_pix_ok_reg;
    logic               s2_blend_reg;
    logic               s2_alpha_reg;
    logic [ADDR_W-1:0]  s2_address_reg;
    logic [DIRTY_W-1:0] s2_dirty_reg;
    prod3_t             s2_prod_a_reg;
    prod3_t             s2_prod_b_reg;
    logic [DATA_W-1:0]  s2_direct_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_line_ok_reg <= s1_line_ok_reg;
        s2_pix_ok_reg  <= s1_pix_ok_reg;
        s2_blend_reg   <= s1_blend_reg;
        s2_alpha_reg   <= (s1_wa_reg != '0) || (s1_wb_reg != '0);
        s2_address_reg <= address;
        s2_dirty_reg   <= s1_base_reg[BASE_W-1:8];
        s2_prod_a_reg  <= prod_a;
        s2_prod_b_reg  <= prod_b;
        s2_direct_reg  <= s1_direct_reg;
    end

    // stage 3: rounded sum, saturation, result beat
    chan3_t            blend_chan;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-ROUND_SHIFT-1:0] scaled;
    logic [DATA_W-1:0] data;
    result_t           result_next;

    always_comb
    begin
        sum    = '0;
        scaled = '0;
        for (int i = 0; i < 3; i++)
        begin
            sum    = s2_prod_a_reg[i] + s2_prod_b_reg[i] + ROUND_ADD;
            scaled = sum[SUM_W-1:ROUND_SHIFT];
            blend_chan[i] = scaled[SUM_W-ROUND_SHIFT-1] ? CHAN_MAX
                                                         : scaled[CHAN_W-1:0];
        end
        data = s2_blend_reg
             ? {s2_alpha_reg, blend_chan[2], blend_chan[1], blend_chan[0]}
             : s2_direct_reg;

        result_next = '0;
        if (s2_line_ok_reg)
        begin
            result_next.dirty_block = s2_dirty_reg;
            if (s2_pix_ok_reg)
            begin
                result_next.write_enable  = 1'b1;
                result_next.write_bank    = bank_reg;
                result_next.write_address = s2_address_reg;
                result_next.write_data    = data;
            end
        end
    end

    logic    done_reg;
    result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
